// ----- src/crsa_pkg.sv -----
// Shared constants for the circular run slot allocator.
// Field widths, mode codes and reset values; no dependencies.
package crsa_pkg;

   // Payload and register widths
   localparam int CNT_W   = 7;   // spot count, run length, counters
   localparam int START_W = 6;   // start index field
   localparam int ANS_W   = 8;   // signed answer field
   localparam int STEP_W  = $clog2(START_W);

   // Default map depth and register reset
   localparam int              MAX_SPOTS_DEF    = 64;
   localparam logic [CNT_W-1:0] SPOT_COUNT_RESET = 7'd64;

   // Request modes
   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Answer when no run fits
   localparam logic signed [ANS_W-1:0] ANS_NO_FIT = -8'sd1;

endpackage

// ----- src/crsa_occ_ram.sv -----
// Occupancy bitmap storage: one write port, one registered read port.
// Stand-alone; no package needed.
module crsa_occ_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   // Write and registered read; a read at the written address sees the old bit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/circular_run_slot_allocator.sv -----
// Circular run slot allocator top level: sequencer, modulo unit and bitmap.
// Depends on crsa_pkg and crsa_occ_ram.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | req_mode, req_start_index, req_slot_count
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_answer
//  csr     | in        | csr_wr_en (no wait)     | csr_wr_data (spot count)
//
// Steps per item: accept, 6 modulo steps, work, result load.
//   store: work = scan of at most n spots (one bitmap read per cycle) plus len mark writes.
//   free:  work = len reads (read, then clear if set on the following cycle).
// The single bitmap read port paces the scan and the release walk.
// After reset a clearing pass over all MAX_SPOTS spots runs before req_ready rises.
// A finished result waits in the output register; the next request is taken meanwhile.
module circular_run_slot_allocator
   import crsa_pkg::*;
#(
   parameter int MAX_SPOTS = MAX_SPOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [START_W-1:0]      req_start_index,
   input  logic [CNT_W-1:0]        req_slot_count,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ANS_W-1:0] rsp_answer,
   // configuration
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data
);

   localparam int PW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
   localparam int XW = ((PW > CNT_W) ? PW : CNT_W) + 1;
   localparam int RW = START_W + CNT_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_FREE,
      ST_MARK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        spot_count_ff, spot_count_in;
   logic [PW-1:0]           clr_addr_ff, clr_addr_in;
   logic                    mode_ff, mode_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [START_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [PW-1:0]           chk_pos_ff, chk_pos_in;
   logic                    rd_live_ff, rd_live_in;
   logic                    fwd_ff, fwd_in;
   logic [PW-1:0]           base_ff, base_in;
   logic [CNT_W-1:0]        run_ff, run_in;
   logic [CNT_W-1:0]        visits_ff, visits_in;
   logic [CNT_W-1:0]        issued_ff, issued_in;
   logic [CNT_W-1:0]        released_ff, released_in;
   logic signed [ANS_W-1:0] result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ANS_W-1:0] rsp_answer_ff, rsp_answer_in;

   logic                    mem_we;
   logic [PW-1:0]           mem_waddr;
   logic                    mem_wdata;
   logic                    mem_rdata;

   logic [CNT_W-1:0]        n_active;
   logic [RW-1:0]           div_term;
   logic [START_W-1:0]      rem_next;

   // Next spot round the circle of n spots
   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p,
                                              input logic [CNT_W-1:0] n);
      logic [XW-1:0] s;
      s = XW'(p) + XW'(1);
      return (s == XW'(n)) ? '0 : PW'(s);
   endfunction

   // Active spot count: zero reads as one, saturate at the map depth
   always_comb begin
      n_active = (spot_count_ff == '0) ? CNT_W'(1) : spot_count_ff;
      if (int'(n_active) > MAX_SPOTS) begin
         n_active = CNT_W'(MAX_SPOTS);
      end
   end

   // Shared shift-subtract step of the start index reduction
   always_comb begin
      div_term = RW'(n_ff) << step_ff;
      rem_next = rem_ff;
      if (RW'(rem_ff) >= div_term) begin
         rem_next = START_W'(RW'(rem_ff) - div_term);
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      spot_count_in = csr_wr_en ? csr_wr_data : spot_count_ff;
      clr_addr_in   = clr_addr_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      chk_pos_in    = chk_pos_ff;
      rd_live_in    = 1'b0;
      fwd_in        = 1'b0;
      base_in       = base_ff;
      run_in        = run_ff;
      visits_in     = visits_ff;
      issued_in     = issued_ff;
      released_in   = released_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = 1'b0;
      req_ready     = (state_ff == ST_IDLE);

      // Output transfer retires the held result
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + PW'(1);
            if (clr_addr_ff == PW'(MAX_SPOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               len_in   = req_slot_count;
               rem_in   = req_start_index;
               n_in     = n_active;
               step_in  = STEP_W'(START_W - 1);
               state_in = ST_REDUCE;
            end
         end

         ST_REDUCE: begin
            rem_in = rem_next;
            if (step_ff == '0) begin
               pos_in      = PW'(rem_next);
               base_in     = PW'(rem_next);
               run_in      = '0;
               visits_in   = '0;
               issued_in   = '0;
               released_in = '0;
               if (len_ff == '0) begin
                  result_in = (mode_ff == MODE_STORE) ? ANS_W'(rem_next) : '0;
                  state_in  = ST_DONE;
               end else if (mode_ff == MODE_STORE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FREE;
               end
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         ST_SCAN: begin
            // stream reads one spot ahead of the check
            pos_in     = wrap_inc(pos_ff, n_ff);
            chk_pos_in = pos_ff;
            rd_live_in = 1'b1;
            if (rd_live_ff) begin
               if (visits_ff == n_ff) begin
                  // every spot seen once already: the search would repeat
                  result_in  = ANS_NO_FIT;
                  rd_live_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  visits_in = visits_ff + CNT_W'(1);
                  if (mem_rdata) begin
                     run_in  = '0;
                     base_in = wrap_inc(chk_pos_ff, n_ff);
                  end else if (run_ff + CNT_W'(1) == len_ff) begin
                     pos_in     = base_ff;
                     issued_in  = '0;
                     rd_live_in = 1'b0;
                     state_in   = ST_MARK;
                  end else begin
                     run_in = run_ff + CNT_W'(1);
                  end
               end
            end
         end

         ST_FREE: begin
            // check and clear the spot read last cycle
            if (rd_live_ff) begin
               visits_in = visits_ff + CNT_W'(1);
               if (mem_rdata && !fwd_ff) begin
                  mem_we      = 1'b1;
                  mem_waddr   = chk_pos_ff;
                  released_in = released_ff + CNT_W'(1);
               end
               if (visits_ff + CNT_W'(1) == len_ff) begin
                  result_in = ANS_W'(released_in);
                  state_in  = ST_DONE;
               end
            end
            // issue the next read; a same-address clear this cycle makes it free
            if (issued_ff != len_ff) begin
               pos_in     = wrap_inc(pos_ff, n_ff);
               chk_pos_in = pos_ff;
               issued_in  = issued_ff + CNT_W'(1);
               rd_live_in = 1'b1;
               fwd_in     = mem_we && (mem_waddr == pos_ff);
            end
         end

         ST_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = 1'b1;
            pos_in    = wrap_inc(pos_ff, n_ff);
            issued_in = issued_ff + CNT_W'(1);
            if (issued_ff + CNT_W'(1) == len_ff) begin
               result_in = ANS_W'(base_ff);
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = result_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         spot_count_ff <= SPOT_COUNT_RESET;
         clr_addr_ff   <= '0;
         rd_live_ff    <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spot_count_ff <= spot_count_in;
         clr_addr_ff   <= clr_addr_in;
         rd_live_ff    <= rd_live_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      len_ff        <= len_in;
      n_ff          <= n_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      pos_ff        <= pos_in;
      chk_pos_ff    <= chk_pos_in;
      base_ff       <= base_in;
      run_ff        <= run_in;
      visits_ff     <= visits_in;
      issued_ff     <= issued_in;
      released_ff   <= released_in;
      result_ff     <= result_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   // Occupancy bitmap
   crsa_occ_ram #(
      .DEPTH  (MAX_SPOTS),
      .ADDR_W (PW)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (pos_ff),
      .rd_data (mem_rdata)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;

endmodule

// ----- src/crsa_checker.sv -----
// Port-level checks for the circular run slot allocator, with its bind.
// Depends on crsa_pkg; attaches to circular_run_slot_allocator.
module crsa_checker
   import crsa_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ANS_W-1:0] rsp_answer
);

   // Reset starts the clearing pass: no request taken, no result shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request taken or result shown right after reset");

   // One item at a time: ready drops after a transfer and does not come straight back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request ready again too soon after a transfer");

   // A new result never appears the cycle after a request transfer
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result shown one cycle after a request transfer");

   // Held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer))
      else $error("pending result dropped or changed");

   // Only the no-fit code is negative
   a_answer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_answer >= ANS_NO_FIT)
      else $error("answer below the no-fit code");

endmodule

bind circular_run_slot_allocator crsa_checker u_crsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_answer (rsp_answer)
);
